// ===== design/cpu_operand_fetch_sequencer_top_macros.svh =====
// assertion macros for the operand fetch sequencer
`ifndef CPU_OPERAND_FETCH_SEQUENCER_TOP_MACROS_SVH
`define CPU_OPERAND_FETCH_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define COFS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define COFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/cofs_pkg.sv =====
`timescale 1ns / 1ps

package cofs_pkg;

   // item kinds on the request channel
   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   // result kinds
   localparam logic KIND_READ   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // addressing modes
   localparam logic [4:0] MODE_NONE   = 5'd0;
   localparam logic [4:0] MODE_IMP    = 5'd1;
   localparam logic [4:0] MODE_R      = 5'd2;
   localparam logic [4:0] MODE_R_R    = 5'd3;
   localparam logic [4:0] MODE_R_D8   = 5'd4;
   localparam logic [4:0] MODE_R_D16  = 5'd5;
   localparam logic [4:0] MODE_D16    = 5'd6;
   localparam logic [4:0] MODE_MR_R   = 5'd7;
   localparam logic [4:0] MODE_R_MR   = 5'd8;
   localparam logic [4:0] MODE_R_HLI  = 5'd9;
   localparam logic [4:0] MODE_R_HLD  = 5'd10;
   localparam logic [4:0] MODE_HLI_R  = 5'd11;
   localparam logic [4:0] MODE_HLD_R  = 5'd12;
   localparam logic [4:0] MODE_R_A8   = 5'd13;
   localparam logic [4:0] MODE_A8_R   = 5'd14;
   localparam logic [4:0] MODE_HL_SPR = 5'd15;
   localparam logic [4:0] MODE_D8     = 5'd16;
   localparam logic [4:0] MODE_A16_R  = 5'd17;
   localparam logic [4:0] MODE_D16_R  = 5'd18;
   localparam logic [4:0] MODE_MR_D8  = 5'd19;
   localparam logic [4:0] MODE_MR     = 5'd20;
   localparam logic [4:0] MODE_R_A16  = 5'd21;

   localparam logic [15:0] HIGH_PAGE = 16'hFF00;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      LOAD_KEEP = 2'd0,
      LOAD_REG1 = 2'd1,
      LOAD_REG2 = 2'd2
   } load_sel_type;

   // what a start beat does, worked out from its own fields
   typedef struct packed {
      logic         is_request;
      logic [15:0]  req_addr;
      load_sel_type load_sel;
      logic         dest_mem;
      logic [15:0]  dest_addr;
      logic         hl_inc;
      logic         hl_dec;
      logic         bad;
   } start_dec_type;

   // one queue entry
   typedef struct packed {
      logic          op;
      logic [4:0]    mode;
      logic [15:0]   reg1;
      logic [15:0]   reg2;
      logic [15:0]   hl;
      logic [15:0]   pc;
      logic [7:0]    bus_data;
      start_dec_type dec;
   } fetch_beat_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] read_address;
      logic [15:0] operand;
      logic [15:0] memory_destination;
      logic        dest_is_memory;
      logic [15:0] new_pc;
      logic        hl_update;
      logic [15:0] new_hl;
      logic [1:0]  machine_cycles;
      logic        bad_mode;
   } rsp_beat_type;

endpackage

// ===== design/cofs_front.sv =====
`timescale 1ns / 1ps

module cofs_front import cofs_pkg::*; (
   input  logic           req_op,
   input  logic [4:0]     req_mode,
   input  logic [15:0]    req_reg1_value,
   input  logic [15:0]    req_reg2_value,
   input  logic           req_reg1_is_c,
   input  logic           req_reg2_is_c,
   input  logic [15:0]    req_hl_value,
   input  logic [15:0]    req_pc_value,
   input  logic [7:0]     req_bus_data,
   output fetch_beat_type beat
);

   start_dec_type dec;
   logic [15:0]   reg1_page;
   logic [15:0]   reg2_page;

   assign reg1_page = req_reg1_value | (req_reg1_is_c ? HIGH_PAGE : 16'd0);
   assign reg2_page = req_reg2_value | (req_reg2_is_c ? HIGH_PAGE : 16'd0);

   always_comb begin
      dec = '0;
      dec.load_sel = LOAD_KEEP;
      unique case (req_mode) inside
         MODE_NONE, MODE_IMP: begin
         end
         MODE_R: begin
            dec.load_sel = LOAD_REG1;
         end
         MODE_R_R: begin
            dec.load_sel = LOAD_REG2;
         end
         MODE_MR_R: begin
            dec.load_sel  = LOAD_REG2;
            dec.dest_mem  = 1'b1;
            dec.dest_addr = reg1_page;
         end
         MODE_HLI_R, MODE_HLD_R: begin
            dec.load_sel  = LOAD_REG2;
            dec.dest_mem  = 1'b1;
            dec.dest_addr = req_reg1_value;
            dec.hl_inc    = (req_mode == MODE_HLI_R);
            dec.hl_dec    = (req_mode == MODE_HLD_R);
         end
         MODE_R_D8, MODE_R_D16, MODE_D16, MODE_R_A8, MODE_A8_R, MODE_HL_SPR, MODE_D8,
         MODE_A16_R, MODE_D16_R, MODE_MR_D8, MODE_R_A16: begin
            dec.is_request = 1'b1;
            dec.req_addr   = req_pc_value;
         end
         MODE_R_MR: begin
            dec.is_request = 1'b1;
            dec.req_addr   = reg2_page;
         end
         MODE_R_HLI, MODE_R_HLD: begin
            dec.is_request = 1'b1;
            dec.req_addr   = req_reg2_value;
         end
         MODE_MR: begin
            dec.is_request = 1'b1;
            dec.req_addr   = req_reg1_value;
         end
         default: begin
            dec.bad = 1'b1;
         end
      endcase
   end

   always_comb begin
      beat.op       = req_op;
      beat.mode     = req_mode;
      beat.reg1     = req_reg1_value;
      beat.reg2     = req_reg2_value;
      beat.hl       = req_hl_value;
      beat.pc       = req_pc_value;
      beat.bus_data = req_bus_data;
      beat.dec      = dec;
   end

endmodule

// ===== design/cofs_queue.sv =====
`timescale 1ns / 1ps

module cofs_queue import cofs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  fetch_beat_type push_beat,
   input  logic           pop,
   output logic           full,
   output logic           head_valid,
   output fetch_beat_type head_beat
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);

   fetch_beat_type entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == (PtrW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_beat  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PtrW+1)'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - (PtrW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

// ===== design/cofs_back.sv =====
`timescale 1ns / 1ps

module cofs_back import cofs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  fetch_beat_type head_beat,
   output logic           pop,
   input  logic           rsp_stall,
   output logic           rsp_valid,
   output rsp_beat_type   rsp_beat
);

   typedef enum logic [3:0] {
      STEP_IDLE  = 4'b0001,
      STEP_READ1 = 4'b0010,
      STEP_READ2 = 4'b0100,
      STEP_READ3 = 4'b1000
   } step_type;

   step_type     step_ff, step_in;
   logic [4:0]   held_mode_ff, held_mode_in;
   logic [15:0]  held_pc_ff, held_pc_in;
   logic [15:0]  held_reg1_ff, held_reg1_in;
   logic [15:0]  held_reg2_ff, held_reg2_in;
   logic [15:0]  held_hl_ff, held_hl_in;
   logic [7:0]   low_byte_ff, low_byte_in;
   logic [15:0]  last_fetched_ff, last_fetched_in;
   logic [1:0]   cycle_count_ff, cycle_count_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_ff, rsp_in;

   logic         out_free;
   logic         emit;
   logic         is_req;
   logic [15:0]  req_addr;
   logic [15:0]  dest;
   logic         mem;
   logic [1:0]   pc_add;
   logic         hl_inc;
   logic         hl_dec;
   logic         bad;
   logic [15:0]  pc_base;
   logic [15:0]  hl_base;
   logic [15:0]  pc_sum;
   logic [15:0]  hl_next;
   logic [15:0]  word;
   logic [7:0]   data;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head_valid && out_free;
   assign data     = head_beat.bus_data;
   assign word     = {data, low_byte_ff};

   always_comb begin
      step_in         = step_ff;
      held_mode_in    = held_mode_ff;
      held_pc_in      = held_pc_ff;
      held_reg1_in    = held_reg1_ff;
      held_reg2_in    = held_reg2_ff;
      held_hl_in      = held_hl_ff;
      low_byte_in     = low_byte_ff;
      last_fetched_in = last_fetched_ff;
      cycle_count_in  = cycle_count_ff;
      emit     = 1'b0;
      is_req   = 1'b0;
      req_addr = '0;
      dest     = '0;
      mem      = 1'b0;
      pc_add   = 2'd0;
      hl_inc   = 1'b0;
      hl_dec   = 1'b0;
      bad      = 1'b0;
      pc_base  = held_pc_ff;
      hl_base  = held_hl_ff;
      if (pop) begin
         if (head_beat.op == OP_START) begin
            // a start beat drops any pending fetch
            emit           = 1'b1;
            held_mode_in   = head_beat.mode;
            held_pc_in     = head_beat.pc;
            held_reg1_in   = head_beat.reg1;
            held_reg2_in   = head_beat.reg2;
            held_hl_in     = head_beat.hl;
            cycle_count_in = 2'd0;
            pc_base        = head_beat.pc;
            hl_base        = head_beat.hl;
            is_req         = head_beat.dec.is_request;
            req_addr       = head_beat.dec.req_addr;
            dest           = head_beat.dec.dest_addr;
            mem            = head_beat.dec.dest_mem;
            hl_inc         = head_beat.dec.hl_inc;
            hl_dec         = head_beat.dec.hl_dec;
            bad            = head_beat.dec.bad;
            case (head_beat.dec.load_sel)
               LOAD_REG1: last_fetched_in = head_beat.reg1;
               LOAD_REG2: last_fetched_in = head_beat.reg2;
               default:   last_fetched_in = last_fetched_ff;
            endcase
            step_in = head_beat.dec.is_request ? STEP_READ1 : STEP_IDLE;
         end else if (step_ff != STEP_IDLE) begin
            // bus data beat answering the pending read
            emit           = 1'b1;
            cycle_count_in = cycle_count_ff + 2'd1;
            step_in        = STEP_IDLE;
            unique case (held_mode_ff) inside
               MODE_R_D8, MODE_R_A8, MODE_HL_SPR, MODE_D8: begin
                  last_fetched_in = {8'd0, data};
                  pc_add          = 2'd1;
               end
               MODE_A8_R: begin
                  dest   = {8'd0, data} | HIGH_PAGE;
                  mem    = 1'b1;
                  pc_add = 2'd1;
               end
               MODE_MR_D8: begin
                  last_fetched_in = {8'd0, data};
                  dest            = held_reg1_ff;
                  mem             = 1'b1;
                  pc_add          = 2'd1;
               end
               MODE_R_MR: begin
                  last_fetched_in = {8'd0, data};
               end
               MODE_R_HLI, MODE_R_HLD: begin
                  last_fetched_in = {8'd0, data};
                  hl_inc          = (held_mode_ff == MODE_R_HLI);
                  hl_dec          = (held_mode_ff == MODE_R_HLD);
               end
               MODE_MR: begin
                  last_fetched_in = {8'd0, data};
                  dest            = held_reg1_ff;
                  mem             = 1'b1;
               end
               MODE_R_D16, MODE_D16, MODE_A16_R, MODE_D16_R, MODE_R_A16: begin
                  unique case (step_ff)
                     STEP_READ1: begin
                        low_byte_in = data;
                        is_req      = 1'b1;
                        req_addr    = held_pc_ff + 16'd1;
                        step_in     = STEP_READ2;
                     end
                     STEP_READ2: begin
                        pc_add = 2'd2;
                        if (held_mode_ff == MODE_R_A16) begin
                           is_req   = 1'b1;
                           req_addr = word;
                           step_in  = STEP_READ3;
                        end else if (held_mode_ff == MODE_A16_R ||
                                     held_mode_ff == MODE_D16_R) begin
                           last_fetched_in = held_reg2_ff;
                           dest            = word;
                           mem             = 1'b1;
                        end else begin
                           last_fetched_in = word;
                        end
                     end
                     default: begin
                        last_fetched_in = {8'd0, data};
                        pc_add          = 2'd2;
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
      end

      pc_sum = pc_base + {14'd0, pc_add};
      if (hl_inc) begin
         hl_next = hl_base + 16'd1;
      end else if (hl_dec) begin
         hl_next = hl_base - 16'd1;
      end else begin
         hl_next = hl_base;
      end

      rsp_in = '0;
      if (is_req) begin
         rsp_in.kind         = KIND_READ;
         rsp_in.read_address = req_addr;
      end else begin
         rsp_in.kind               = KIND_FINISH;
         rsp_in.operand            = last_fetched_in;
         rsp_in.memory_destination = mem ? dest : 16'd0;
         rsp_in.dest_is_memory     = mem;
         rsp_in.new_pc             = pc_sum;
         rsp_in.hl_update          = hl_inc || hl_dec;
         rsp_in.new_hl             = hl_next;
         rsp_in.machine_cycles     = cycle_count_in;
         rsp_in.bad_mode           = bad;
      end

      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff         <= STEP_IDLE;
         last_fetched_ff <= '0;
         cycle_count_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         step_ff         <= step_in;
         last_fetched_ff <= last_fetched_in;
         cycle_count_ff  <= cycle_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_mode_ff <= held_mode_in;
      held_pc_ff   <= held_pc_in;
      held_reg1_ff <= held_reg1_in;
      held_reg2_ff <= held_reg2_in;
      held_hl_ff   <= held_hl_in;
      low_byte_ff  <= low_byte_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule

// ===== design/cpu_operand_fetch_sequencer_top.sv =====
`timescale 1ns / 1ps
`include "cpu_operand_fetch_sequencer_top_macros.svh"

// Operand fetch sequencer for an 8-bit CPU. A start beat (op 0) brings the addressing
// mode and the register, HL and PC values; a data beat (op 1) brings the byte read for
// the last bus read request. Every start beat, and every data beat while a read is
// pending, gives exactly one result beat: either a bus read request (kind 0) or the
// finished fetch (kind 1) with operand, memory destination, new PC, HL update, read
// count and an unknown-mode flag. Data beats with no read pending are dropped without
// a result. The block takes one beat per cycle while req_stall is low: a front stage
// classifies the mode of a start beat, a two-entry queue decouples it from the back
// stage, which holds the fetch state and registers one result per cycle unless rsp_stall
// holds back the last one. An accepted beat passes through a queue entry and then the
// result register; req_stall rises only when the queue is full because rsp_stall has held back results.
module cpu_operand_fetch_sequencer_top import cofs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [4:0]  req_mode,
   input  logic [15:0] req_reg1_value,
   input  logic [15:0] req_reg2_value,
   input  logic        req_reg1_is_c,
   input  logic        req_reg2_is_c,
   input  logic [15:0] req_hl_value,
   input  logic [15:0] req_pc_value,
   input  logic [7:0]  req_bus_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [15:0] rsp_read_address,
   output logic [15:0] rsp_operand,
   output logic [15:0] rsp_memory_destination,
   output logic        rsp_dest_is_memory,
   output logic [15:0] rsp_new_pc,
   output logic        rsp_hl_update,
   output logic [15:0] rsp_new_hl,
   output logic [1:0]  rsp_machine_cycles,
   output logic        rsp_bad_mode
);

   fetch_beat_type front_beat;
   fetch_beat_type head_beat;
   logic           q_full;
   logic           head_valid;
   logic           pop;
   rsp_beat_type   rsp_beat;

   // front: decode the addressing mode of a start beat
   cofs_front u_front (
      .req_op         (req_op),
      .req_mode       (req_mode),
      .req_reg1_value (req_reg1_value),
      .req_reg2_value (req_reg2_value),
      .req_reg1_is_c  (req_reg1_is_c),
      .req_reg2_is_c  (req_reg2_is_c),
      .req_hl_value   (req_hl_value),
      .req_pc_value   (req_pc_value),
      .req_bus_data   (req_bus_data),
      .beat           (front_beat)
   );

   // queue between front and back, the only source of backpressure on the input
   cofs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_beat  (front_beat),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_beat  (head_beat)
   );

   assign req_stall = q_full;

   // back: fetch state, read sequencing and the result register
   cofs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_beat  (head_beat),
      .pop        (pop),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_beat   (rsp_beat)
   );

   // result fields out to the ports
   assign rsp_kind               = rsp_beat.kind;
   assign rsp_read_address       = rsp_beat.read_address;
   assign rsp_operand            = rsp_beat.operand;
   assign rsp_memory_destination = rsp_beat.memory_destination;
   assign rsp_dest_is_memory     = rsp_beat.dest_is_memory;
   assign rsp_new_pc             = rsp_beat.new_pc;
   assign rsp_hl_update          = rsp_beat.hl_update;
   assign rsp_new_hl             = rsp_beat.new_hl;
   assign rsp_machine_cycles     = rsp_beat.machine_cycles;
   assign rsp_bad_mode           = rsp_beat.bad_mode;

   // an unknown mode finishes at once with no side effects
   `COFS_ASSERT_IMPL(a_bad_mode_clean, rsp_valid && rsp_bad_mode,
      rsp_kind == KIND_FINISH && rsp_machine_cycles == 2'd0 && !rsp_dest_is_memory
      && !rsp_hl_update, "bad mode result carries side effects")
   // a read request carries no finish information
   `COFS_ASSERT_IMPL(a_read_req_clean, rsp_valid && rsp_kind == KIND_READ,
      !rsp_hl_update && !rsp_bad_mode && !rsp_dest_is_memory && rsp_machine_cycles == 2'd0,
      "read request carries finish fields")
   // a result beat taken while the queue was full frees space on the next cycle
   `COFS_ASSERT_NEXT(a_queue_drains, req_stall && rsp_valid && !rsp_stall && !req_valid,
      !req_stall, "queue did not drain after a result was taken")

endmodule

// ===== sim/tb_cpu_operand_fetch_sequencer_top.sv =====
`timescale 1ns / 1ps

module tb_cpu_operand_fetch_sequencer_top;
   import cofs_pkg::*;

   // run limits
   localparam int LIMIT_CYCLES = 400000;   // several times the slowest legal run
   localparam int HOLD_CYCLES  = 150;      // long receiver hold-off, fills the queue
   localparam int DRAIN_CYCLES = 16;       // queue entries and the result register, with margin
   localparam int RANDOM_BEATS = 1100;
   localparam int MAX_PRINTED  = 30;

   // mode codes past the last defined addressing mode
   localparam logic [4:0] MODE_UNKNOWN_LOW  = 5'd22;
   localparam logic [4:0] MODE_UNKNOWN_HIGH = 5'd31;

   // one request-channel beat, field for field
   typedef struct packed {
      logic        op;
      logic [4:0]  mode;
      logic [15:0] reg1;
      logic [15:0] reg2;
      logic        r1c;
      logic        r2c;
      logic [15:0] hl;
      logic [15:0] pc;
      logic [7:0]  data;
   } cmd_beat_type;

   // predicts the result beat of each accepted request beat and checks what comes out
   class fetch_scoreboard;
      rsp_beat_type expected_q[$];

      // predicted sequencer state
      logic [1:0]  step;
      logic [4:0]  held_mode;
      logic [15:0] held_pc;
      logic [15:0] held_reg1;
      logic [15:0] held_reg2;
      logic [15:0] held_hl;
      logic        held_r1c;
      logic        held_r2c;
      logic [7:0]  low_byte;
      logic [15:0] last_fetched;
      logic [1:0]  read_count;

      int          starts;
      int          data_beats;
      int          dropped;
      int          checked;
      int          errors;
      logic [31:0] modes_seen;

      function new();
         step = 0;
         held_mode = 0;
         held_pc = 0;
         held_reg1 = 0;
         held_reg2 = 0;
         held_hl = 0;
         held_r1c = 0;
         held_r2c = 0;
         low_byte = 0;
         last_fetched = 0;
         read_count = 0;
         starts = 0;
         data_beats = 0;
         dropped = 0;
         checked = 0;
         errors = 0;
         modes_seen = '0;
      endfunction

      function void push_finish(logic [15:0] dest, logic mem, logic [15:0] pc_add,
                                int hl_dir, logic bad);
         rsp_beat_type r;
         logic [15:0]  hl;
         hl = held_hl;
         if (hl_dir > 0) hl = hl + 16'd1;
         if (hl_dir < 0) hl = hl - 16'd1;
         r = '0;
         r.kind = KIND_FINISH;
         r.operand = last_fetched;
         r.memory_destination = mem ? dest : 16'h0000;
         r.dest_is_memory = mem;
         r.new_pc = held_pc + pc_add;
         r.hl_update = (hl_dir != 0);
         r.new_hl = hl;
         r.machine_cycles = read_count;
         r.bad_mode = bad;
         expected_q.push_back(r);
         step = 0;
      endfunction

      function void push_read(logic [15:0] addr, logic [1:0] next_step);
         rsp_beat_type r;
         r = '0;
         r.kind = KIND_READ;
         r.read_address = addr;
         expected_q.push_back(r);
         step = next_step;
      endfunction

      function void note_beat(cmd_beat_type c);
         logic [15:0] word;
         if (c.op == OP_START) begin
            starts++;
            modes_seen[c.mode] = 1'b1;
            held_mode = c.mode;
            held_reg1 = c.reg1;
            held_reg2 = c.reg2;
            held_r1c = c.r1c;
            held_r2c = c.r2c;
            held_hl = c.hl;
            held_pc = c.pc;
            read_count = 0;
            case (held_mode)
               MODE_NONE, MODE_IMP: begin
                  push_finish(16'h0, 1'b0, 16'd0, 0, 1'b0);
               end
               MODE_R: begin
                  last_fetched = held_reg1;
                  push_finish(16'h0, 1'b0, 16'd0, 0, 1'b0);
               end
               MODE_R_R: begin
                  last_fetched = held_reg2;
                  push_finish(16'h0, 1'b0, 16'd0, 0, 1'b0);
               end
               MODE_MR_R: begin
                  last_fetched = held_reg2;
                  push_finish(held_reg1 | (held_r1c ? HIGH_PAGE : 16'h0), 1'b1, 16'd0, 0,
                              1'b0);
               end
               MODE_HLI_R, MODE_HLD_R: begin
                  last_fetched = held_reg2;
                  push_finish(held_reg1, 1'b1, 16'd0, (held_mode == MODE_HLI_R) ? 1 : -1,
                              1'b0);
               end
               MODE_R_D8, MODE_R_D16, MODE_D16, MODE_R_A8, MODE_A8_R, MODE_HL_SPR, MODE_D8,
               MODE_A16_R, MODE_D16_R, MODE_MR_D8, MODE_R_A16: begin
                  push_read(held_pc, 2'd1);
               end
               MODE_R_MR: begin
                  push_read(held_reg2 | (held_r2c ? HIGH_PAGE : 16'h0), 2'd1);
               end
               MODE_R_HLI, MODE_R_HLD: begin
                  push_read(held_reg2, 2'd1);
               end
               MODE_MR: begin
                  push_read(held_reg1, 2'd1);
               end
               default: begin
                  push_finish(16'h0, 1'b0, 16'd0, 0, 1'b1);
               end
            endcase
         end else if (step == 0) begin
            dropped++;
         end else begin
            data_beats++;
            read_count = read_count + 2'd1;
            case (held_mode)
               MODE_R_D8, MODE_R_A8, MODE_HL_SPR, MODE_D8: begin
                  last_fetched = {8'h00, c.data};
                  push_finish(16'h0, 1'b0, 16'd1, 0, 1'b0);
               end
               MODE_A8_R: begin
                  push_finish(HIGH_PAGE | {8'h00, c.data}, 1'b1, 16'd1, 0, 1'b0);
               end
               MODE_MR_D8: begin
                  last_fetched = {8'h00, c.data};
                  push_finish(held_reg1, 1'b1, 16'd1, 0, 1'b0);
               end
               MODE_R_MR: begin
                  last_fetched = {8'h00, c.data};
                  push_finish(16'h0, 1'b0, 16'd0, 0, 1'b0);
               end
               MODE_R_HLI, MODE_R_HLD: begin
                  last_fetched = {8'h00, c.data};
                  push_finish(16'h0, 1'b0, 16'd0, (held_mode == MODE_R_HLI) ? 1 : -1, 1'b0);
               end
               MODE_MR: begin
                  last_fetched = {8'h00, c.data};
                  push_finish(held_reg1, 1'b1, 16'd0, 0, 1'b0);
               end
               MODE_R_D16, MODE_D16, MODE_A16_R, MODE_D16_R, MODE_R_A16: begin
                  if (step == 2'd1) begin
                     low_byte = c.data;
                     push_read(held_pc + 16'd1, 2'd2);
                  end else if (step == 2'd2) begin
                     word = {c.data, low_byte};
                     if (held_mode == MODE_R_A16) begin
                        push_read(word, 2'd3);
                     end else if (held_mode == MODE_A16_R || held_mode == MODE_D16_R) begin
                        last_fetched = held_reg2;
                        push_finish(word, 1'b1, 16'd2, 0, 1'b0);
                     end else begin
                        last_fetched = word;
                        push_finish(16'h0, 1'b0, 16'd2, 0, 1'b0);
                     end
                  end else begin
                     last_fetched = {8'h00, c.data};
                     push_finish(16'h0, 1'b0, 16'd2, 0, 1'b0);
                  end
               end
               default: begin
                  push_finish(16'h0, 1'b0, 16'd0, 0, 1'b0);
               end
            endcase
         end
      endfunction

      task report(string what);
         errors++;
         if (errors <= MAX_PRINTED) $display("%0t ns mismatch: %s", $time, what);
      endtask

      task cmp(string field, logic [15:0] got, logic [15:0] want);
         if (got !== want) report($sformatf("%s got %h want %h", field, got, want));
      endtask

      task check_result(rsp_beat_type got);
         rsp_beat_type want;
         checked++;
         if (expected_q.size() == 0) begin
            report($sformatf("result beat with nothing expected, kind %b", got.kind));
            return;
         end
         want = expected_q.pop_front();
         cmp("kind", got.kind, want.kind);
         cmp("read_address", got.read_address, want.read_address);
         cmp("operand", got.operand, want.operand);
         cmp("memory_destination", got.memory_destination, want.memory_destination);
         cmp("dest_is_memory", got.dest_is_memory, want.dest_is_memory);
         cmp("new_pc", got.new_pc, want.new_pc);
         cmp("hl_update", got.hl_update, want.hl_update);
         cmp("new_hl", got.new_hl, want.new_hl);
         cmp("machine_cycles", got.machine_cycles, want.machine_cycles);
         cmp("bad_mode", got.bad_mode, want.bad_mode);
      endtask
   endclass

   // block ports, all inputs known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_START;
   logic [4:0]  req_mode = MODE_NONE;
   logic [15:0] req_reg1_value = 16'h0;
   logic [15:0] req_reg2_value = 16'h0;
   logic        req_reg1_is_c = 1'b0;
   logic        req_reg2_is_c = 1'b0;
   logic [15:0] req_hl_value = 16'h0;
   logic [15:0] req_pc_value = 16'h0;
   logic [7:0]  req_bus_data = 8'h0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [15:0] rsp_read_address;
   logic [15:0] rsp_operand;
   logic [15:0] rsp_memory_destination;
   logic        rsp_dest_is_memory;
   logic [15:0] rsp_new_pc;
   logic        rsp_hl_update;
   logic [15:0] rsp_new_hl;
   logic [1:0]  rsp_machine_cycles;
   logic        rsp_bad_mode;

   // shared between the sender and the receiver process
   bit quiet = 1'b0;          // no idling on either side
   bit hold_off_req = 1'b0;   // ask the receiver for one long hold-off
   bit draining = 1'b0;       // end of run, receiver always ready
   int cycle_count = 0;
   int held_in_cycles = 0;    // cycles the block pushed back on the sender

   fetch_scoreboard sb = new();

   cpu_operand_fetch_sequencer_top dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results still expected", cycle_count,
                  sb.expected_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // both channels sampled at the edge, before any driven value changes
   always @(posedge clock) begin : watch_channels
      cmd_beat_type seen;
      rsp_beat_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.kind = rsp_kind;
            got.read_address = rsp_read_address;
            got.operand = rsp_operand;
            got.memory_destination = rsp_memory_destination;
            got.dest_is_memory = rsp_dest_is_memory;
            got.new_pc = rsp_new_pc;
            got.hl_update = rsp_hl_update;
            got.new_hl = rsp_new_hl;
            got.machine_cycles = rsp_machine_cycles;
            got.bad_mode = rsp_bad_mode;
            sb.check_result(got);
         end
         if (req_valid && !req_stall) begin
            seen.op = req_op;
            seen.mode = req_mode;
            seen.reg1 = req_reg1_value;
            seen.reg2 = req_reg2_value;
            seen.r1c = req_reg1_is_c;
            seen.r2c = req_reg2_is_c;
            seen.hl = req_hl_value;
            seen.pc = req_pc_value;
            seen.data = req_bus_data;
            sb.note_beat(seen);
         end
         if (req_valid && req_stall) held_in_cycles++;
      end
   end

   // receiver: runs of ready and stall, one assignment per run
   initial begin : rsp_stall_gen
      int  r;
      int  len;
      logic v;
      wait (!reset);
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (hold_off_req) begin
            // long hold-off so the queue fills and the input gets pushed back
            v = 1'b1;
            len = HOLD_CYCLES;
            hold_off_req = 1'b0;
         end else if (draining || quiet) begin
            v = 1'b0;
            len = 1;
         end else if (r < 60) begin
            v = 1'b0;
            len = $urandom_range(1, 6);
         end else if (r < 92) begin
            v = 1'b1;
            len = $urandom_range(1, 3);
         end else begin
            v = 1'b1;
            len = $urandom_range(10, 30);
         end
         rsp_stall <= v;
         repeat (len) @(posedge clock);
      end
   end

   function automatic cmd_beat_type noise_beat();
      cmd_beat_type c;
      c.op = 1'($urandom);
      c.mode = 5'($urandom);
      c.reg1 = 16'($urandom);
      c.reg2 = 16'($urandom);
      c.r1c = 1'($urandom);
      c.r2c = 1'($urandom);
      c.hl = 16'($urandom);
      c.pc = 16'($urandom);
      c.data = 8'($urandom);
      return c;
   endfunction

   // mostly random, now and then one of the wrapping extremes
   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'hFFFE;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int reads_needed(logic [4:0] mode);
      case (mode)
         MODE_R_D8, MODE_R_MR, MODE_R_HLI, MODE_R_HLD, MODE_R_A8, MODE_A8_R, MODE_HL_SPR,
         MODE_D8, MODE_MR_D8, MODE_MR: return 1;
         MODE_R_D16, MODE_D16, MODE_A16_R, MODE_D16_R: return 2;
         MODE_R_A16: return 3;
         default: return 0;
      endcase
   endfunction

   // offer one beat after a random gap and return at the edge that takes it
   task automatic put_beat(cmd_beat_type c);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(6, 25);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= c.op;
      req_mode <= c.mode;
      req_reg1_value <= c.reg1;
      req_reg2_value <= c.reg2;
      req_reg1_is_c <= c.r1c;
      req_reg2_is_c <= c.r2c;
      req_hl_value <= c.hl;
      req_pc_value <= c.pc;
      req_bus_data <= c.data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // start beat, then as many bus data beats as asked, low byte of data_bytes first
   task automatic run_fetch(logic [4:0] mode, logic [15:0] reg1, logic [15:0] reg2,
                            logic r1c, logic r2c, logic [15:0] hl, logic [15:0] pc,
                            int reads, logic [23:0] data_bytes);
      cmd_beat_type c;
      c = noise_beat();
      c.op = OP_START;
      c.mode = mode;
      c.reg1 = reg1;
      c.reg2 = reg2;
      c.r1c = r1c;
      c.r2c = r2c;
      c.hl = hl;
      c.pc = pc;
      put_beat(c);
      for (int i = 0; i < reads; i++) begin
         c = noise_beat();
         c.op = OP_DATA;
         c.data = data_bytes[8*i +: 8];
         put_beat(c);
      end
   endtask

   initial begin : stimulus
      cmd_beat_type c;
      int           sent;
      int           quiet_left;
      int           pick;
      int           n;
      int           reads;
      bit           hold_done;
      logic [4:0]   m;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // data beat straight after reset: nothing pending, must be dropped
      c = noise_beat();
      c.op = OP_DATA;
      put_beat(c);

      // no instruction and implied modes keep the previous operand, register mode loads reg1
      run_fetch(MODE_NONE, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 0, 24'h0);
      run_fetch(MODE_R, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 0, 24'h0);
      run_fetch(MODE_IMP, 16'h1234, 16'h5678, 1'b0, 1'b0, 16'h9ABC, 16'hDEF0, 0, 24'h0);
      // pointer through C lands in the high page
      run_fetch(MODE_MR_R, 16'h0012, 16'h5AA5, 1'b1, 1'b0, 16'h1234, 16'h0100, 0, 24'h0);
      // hl increment and decrement across the wrap
      run_fetch(MODE_HLI_R, 16'hC000, 16'hFFFF, 1'b0, 1'b0, 16'hFFFF, 16'h0200, 0, 24'h0);
      run_fetch(MODE_HLD_R, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0300, 0, 24'h0);
      // immediate at the top of memory, pc wraps
      run_fetch(MODE_R_D8, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h4000, 16'hFFFF, 1, 24'hFF);
      run_fetch(MODE_R_MR, 16'h0000, 16'h00AB, 1'b0, 1'b1, 16'h4000, 16'h0400, 1, 24'h00);
      run_fetch(MODE_R_HLD, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 16'h8000, 1, 24'h5A);
      // a8 destination keeps the old operand
      run_fetch(MODE_A8_R, 16'h0001, 16'h0002, 1'b0, 1'b0, 16'h0003, 16'h0004, 1, 24'h80);
      run_fetch(MODE_D16_R, 16'h0000, 16'hBEEF, 1'b0, 1'b0, 16'h7777, 16'hFFFE, 2,
                24'h00FF01);
      // three reads, the last through the fetched address
      run_fetch(MODE_R_A16, 16'hAAAA, 16'h5555, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 3,
                24'hA53412);
      // C flag on reg1 does not page an mr destination
      run_fetch(MODE_MR, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 16'h0000, 16'h1000, 1, 24'hC3);
      run_fetch(MODE_UNKNOWN_HIGH, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 0,
                24'h0);
      // new start while a 16-bit immediate is half read
      run_fetch(MODE_R_D16, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h2000, 1, 24'h77);
      run_fetch(MODE_R_R, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 16'h3000, 0, 24'h0);

      // random part: mostly complete fetches, some cut short, a few stray data beats
      sent = 0;
      quiet_left = 0;
      hold_done = 1'b0;
      while (sent < RANDOM_BEATS) begin
         if (sent >= 300 && !hold_done) begin
            hold_off_req = 1'b1;
            hold_done = 1'b1;
            quiet_left = 40;
         end else if (quiet_left == 0 && $urandom_range(0, 59) == 0) begin
            quiet_left = $urandom_range(15, 40);
         end
         quiet = (quiet_left > 0);
         if (quiet_left > 0) quiet_left--;

         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 9) == 0) m = 5'($urandom_range(MODE_UNKNOWN_LOW,
                                                              MODE_UNKNOWN_HIGH));
         else m = 5'($urandom_range(MODE_NONE, MODE_R_A16));
         n = reads_needed(m);
         if (pick < 85) reads = n;
         else if (pick < 95) reads = (n > 0) ? $urandom_range(0, n - 1) : 0;
         else reads = -1;

         if (reads < 0) begin
            // stray data beat: dropped if idle, else taken as the next read
            c = noise_beat();
            c.op = OP_DATA;
            put_beat(c);
         end else begin
            run_fetch(m, pick16(), pick16(), 1'($urandom), 1'($urandom), pick16(), pick16(),
                      reads, 24'($urandom));
            sent += 1 + reads;
         end
      end
      quiet = 1'b0;

      // wind down: stop offering, let every expected result come out
      req_valid <= 1'b0;
      draining = 1'b1;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d fetch starts over %0d of 32 mode codes, %0d bus data beats taken,",
               sb.starts, $countones(sb.modes_seen), sb.data_beats);
      $display("%0d data beats dropped while idle, %0d result beats checked, input held %0d",
               sb.dropped, sb.checked, held_in_cycles);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
